FILE: design/lfuc_pkg.sv
// package: shared types and constants of the lfu cache table
package lfuc_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // command codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // register index as seen on paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic upd_rd;
        logic decide;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic cap_zero;
        logic idx_last;
        logic need_upd;
    } dp_sts_t;

endpackage

FILE: design/lfuc_ram.sv
// generic single write port ram with registered read
module lfuc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/lfuc_datapath.sv
// datapath: entry table, scan for match and victim, rank update pass, result register
module lfuc_datapath #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lfuc_pkg::dp_cmd_t            cmd,
    output lfuc_pkg::dp_sts_t            sts,
    input  logic [lfuc_pkg::CAP_W-1:0]   capacity,
    input  logic                         in_command,
    input  logic [lfuc_pkg::DATA_W-1:0]  in_key,
    input  logic [lfuc_pkg::DATA_W-1:0]  in_value,
    output logic                         out_hit,
    output logic [lfuc_pkg::DATA_W-1:0]  out_read_value,
    output logic                         out_evicted
);

    localparam int DW = lfuc_pkg::DATA_W;
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RW = IW;
    localparam int FW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = (FW > lfuc_pkg::CAP_W) ? FW : lfuc_pkg::CAP_W;
    localparam int EW = 3 * DW + RW;

    logic                   cmd_reg;
    logic [DW-1:0]          key_reg;
    logic [DW-1:0]          val_reg;
    logic [IW-1:0]          idx_reg;
    logic                   pipe_v_reg;
    logic                   pipe_upd_reg;
    logic [IW-1:0]          pipe_idx_reg;
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [FW-1:0]          fill_reg;

    logic                   hit_reg;
    logic [IW-1:0]          hit_slot_reg;
    logic [RW-1:0]          hit_rank_reg;
    logic [DW-1:0]          hit_val_reg;
    logic                   free_reg;
    logic [IW-1:0]          free_slot_reg;
    logic                   vic_reg;
    logic [IW-1:0]          vic_slot_reg;
    logic [DW-1:0]          vic_cnt_reg;
    logic [RW-1:0]          vic_rank_reg;

    logic [IW-1:0]          slot_reg;
    logic [RW-1:0]          ref_rank_reg;
    logic                   ins_reg;
    logic                   evict_reg;

    logic                   m_hit_reg;
    logic [DW-1:0]          m_read_value_reg;
    logic                   m_evicted_reg;

    logic [EW-1:0]          rdata;
    logic [EW-1:0]          wdata;
    logic                   we;
    logic [DW-1:0]          rd_key;
    logic [DW-1:0]          rd_val;
    logic [DW-1:0]          rd_cnt;
    logic [RW-1:0]          rd_rank;
    logic                   pv;
    logic                   scan_v;
    logic                   upd_v;
    logic                   match_now;
    logic                   free_now;
    logic                   vic_now;
    logic                   fill_ok;
    logic                   is_get;
    logic                   is_put;
    logic                   at_slot;
    logic [DW-1:0]          new_cnt;
    logic [DW-1:0]          new_val;
    logic [RW-1:0]          aged_rank;

    lfuc_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (pipe_idx_reg),
        .wdata (wdata),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    assign rd_key  = rdata[EW-1 -: DW];
    assign rd_val  = rdata[EW-DW-1 -: DW];
    assign rd_cnt  = rdata[EW-2*DW-1 -: DW];
    assign rd_rank = rdata[RW-1:0];

    assign pv     = valid_reg[pipe_idx_reg];
    assign scan_v = pipe_v_reg && !pipe_upd_reg;
    assign upd_v  = pipe_v_reg && pipe_upd_reg;
    assign is_get = (cmd_reg == lfuc_pkg::CMD_GET);
    assign is_put = (cmd_reg == lfuc_pkg::CMD_PUT);

    // scan compare on returned entry
    assign match_now = scan_v && pv && (rd_key == key_reg) && !hit_reg;
    assign free_now  = scan_v && !pv && !free_reg;
    assign vic_now   = scan_v && pv && (!vic_reg || (rd_cnt < vic_cnt_reg) ||
                       ((rd_cnt == vic_cnt_reg) && (rd_rank > vic_rank_reg)));

    assign fill_ok = (CW'(fill_reg) < CW'(capacity)) && (fill_reg != FW'(MAX_ENTRIES));

    // update pass
    assign at_slot   = (pipe_idx_reg == slot_reg);
    assign new_cnt   = !hit_reg ? DW'(1) : ((rd_cnt == '1) ? rd_cnt : rd_cnt + DW'(1));
    assign new_val   = (hit_reg && is_get) ? rd_val : val_reg;
    assign aged_rank = (ins_reg || (rd_rank < ref_rank_reg)) ? rd_rank + RW'(1) : rd_rank;
    assign we        = upd_v && (at_slot || pv);
    assign wdata     = at_slot ? {key_reg, new_val, new_cnt, RW'(0)}
                               : {rd_key, rd_val, rd_cnt, aged_rank};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            pipe_v_reg   <= 1'b0;
            pipe_upd_reg <= 1'b0;
            valid_reg    <= '0;
            fill_reg     <= '0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            vic_reg      <= 1'b0;
            ins_reg      <= 1'b0;
            evict_reg    <= 1'b0;
        end else begin
            pipe_v_reg   <= cmd.scan_rd || cmd.upd_rd;
            pipe_upd_reg <= cmd.upd_rd;
            pipe_idx_reg <= idx_reg;

            if (cmd.scan_rd || cmd.upd_rd) begin
                idx_reg <= sts.idx_last ? '0 : idx_reg + IW'(1);
            end

            if (cmd.load) begin
                cmd_reg   <= in_command;
                key_reg   <= in_key;
                val_reg   <= in_value;
                idx_reg   <= '0;
                hit_reg   <= 1'b0;
                free_reg  <= 1'b0;
                vic_reg   <= 1'b0;
                ins_reg   <= 1'b0;
                evict_reg <= 1'b0;
            end

            if (match_now) begin
                hit_reg      <= 1'b1;
                hit_slot_reg <= pipe_idx_reg;
                hit_rank_reg <= rd_rank;
                hit_val_reg  <= rd_val;
            end
            if (free_now) begin
                free_reg      <= 1'b1;
                free_slot_reg <= pipe_idx_reg;
            end
            if (vic_now) begin
                vic_reg      <= 1'b1;
                vic_slot_reg <= pipe_idx_reg;
                vic_cnt_reg  <= rd_cnt;
                vic_rank_reg <= rd_rank;
            end

            if (cmd.decide) begin
                if (hit_reg) begin
                    slot_reg     <= hit_slot_reg;
                    ref_rank_reg <= hit_rank_reg;
                end else if (is_put && free_reg && fill_ok) begin
                    slot_reg <= free_slot_reg;
                    ins_reg  <= 1'b1;
                    fill_reg <= fill_reg + FW'(1);
                end else if (is_put) begin
                    slot_reg     <= vic_slot_reg;
                    ref_rank_reg <= vic_rank_reg;
                    evict_reg    <= 1'b1;
                end
            end

            if (upd_v && at_slot) begin
                valid_reg[slot_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_hit_reg        <= hit_reg;
            m_read_value_reg <= (hit_reg && is_get) ? hit_val_reg : '0;
            m_evicted_reg    <= evict_reg;
        end
    end

    assign sts.cap_zero = (capacity == '0);
    assign sts.idx_last = (idx_reg == IW'(MAX_ENTRIES - 1));
    assign sts.need_upd = hit_reg || is_put;

    assign out_hit        = m_hit_reg;
    assign out_read_value = m_read_value_reg;
    assign out_evicted    = m_evicted_reg;

endmodule

FILE: design/lfuc_ctrl.sv
// controller: sequences accept, table scan, rank update pass and result handoff
module lfuc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output lfuc_pkg::dp_cmd_t   cmd,
    input  lfuc_pkg::dp_sts_t   sts
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_SCAN     = 7'b0000010,
        ST_SCAN_END = 7'b0000100,
        ST_DECIDE   = 7'b0001000,
        ST_UPDATE   = 7'b0010000,
        ST_UPD_END  = 7'b0100000,
        ST_RESULT   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.cap_zero ? ST_RESULT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (sts.idx_last) begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = sts.need_upd ? ST_UPDATE : ST_RESULT;
            end
            ST_UPDATE: begin
                cmd.upd_rd = 1'b1;
                if (sts.idx_last) begin
                    state_next = ST_UPD_END;
                end
            end
            ST_UPD_END: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

FILE: design/lfu_cache_table_core.sv
// top level: lfu cache table with lru tie break, apb capacity register
// a get miss takes only the match and victim scan over the entry ram; a get hit and a put
// also take a second pass (rank and count writeback), each pass reading one entry per
// cycle; capacity zero skips both passes
// throughput: one transaction in flight, next taken the cycle after the result is loaded
// reset: synchronous active-low aresetn clears all entries and sets capacity to 16
module lfu_cache_table_core #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic [31:0]                       s_lookup_key,
    input  logic signed [31:0]                s_write_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic signed [31:0]                m_read_value,
    output logic                              m_evicted,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lfuc_pkg::APB_AW-1:0]       paddr,
    input  logic [lfuc_pkg::APB_DW-1:0]       pwdata,
    output logic [lfuc_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    lfuc_pkg::dp_cmd_t               cmd;
    lfuc_pkg::dp_sts_t               sts;
    logic [lfuc_pkg::CAP_W-1:0]      cap_reg;
    logic [lfuc_pkg::DATA_W-1:0]     read_value;
    logic                            sel_cap;

    assign sel_cap = (paddr[2] == lfuc_pkg::REG_CAPACITY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= lfuc_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && pready && sel_cap) begin
            cap_reg <= pwdata[lfuc_pkg::CAP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = sel_cap ? lfuc_pkg::APB_DW'(cap_reg) : '0;

    lfuc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    lfuc_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .capacity       (cap_reg),
        .in_command     (s_command),
        .in_key         (s_lookup_key),
        .in_value       (s_write_value),
        .out_hit        (m_hit),
        .out_read_value (read_value),
        .out_evicted    (m_evicted)
    );

    assign m_read_value = $signed(read_value);

endmodule

FILE: design/lfuc_checker.sv
// checker: port-level properties of the lfu cache table, bound to the top level
module lfuc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_hit,
    input logic signed [31:0] m_read_value,
    input logic               m_evicted
);

    // result channel empty right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one transaction at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // no value returned without a hit
    a_value_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_read_value == 32'sd0)
        else $error("read value without hit");

    // eviction only on a miss
    a_evict_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_evicted |-> !m_hit)
        else $error("eviction reported on a hit");

    // stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_evicted)
            && $stable(m_read_value))
        else $error("stalled result changed");

endmodule

bind lfu_cache_table_core lfuc_checker u_lfuc_checker (.*);

FILE: verif/lfu_cache_mirror_pkg.sv
`timescale 1ns / 100ps
// package: lfu cache predictor and result scoreboard for the cache table test
package lfu_cache_mirror_pkg;
    import lfuc_pkg::*;

    localparam int TABLE_SLOTS  = 16;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
    } access_outcome_t;

    class lfu_cache_mirror;
        logic [CAP_W-1:0]         capacity;
        logic                     slot_valid [TABLE_SLOTS];
        logic [DATA_W-1:0]        slot_key   [TABLE_SLOTS];
        logic signed [DATA_W-1:0] slot_value [TABLE_SLOTS];
        logic [31:0]              slot_uses  [TABLE_SLOTS];
        logic [3:0]               slot_rank  [TABLE_SLOTS];
        int                       fill;
        access_outcome_t          pending_outcomes [$];
        int                       mismatches;
        int                       gets;
        int                       puts;
        int                       hits;
        int                       evictions;
        int                       results_seen;

        function new();
            capacity = CAP_RESET;
            fill = 0;
            foreach (slot_valid[i]) begin
                slot_valid[i] = 1'b0;
                slot_key[i]   = '0;
                slot_value[i] = '0;
                slot_uses[i]  = '0;
                slot_rank[i]  = '0;
            end
        endfunction

        function void note_mismatch(string what);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("mismatch: %s", what);
            end
        endfunction

        // predicts the outcome of one accepted transaction and updates the table copy
        function void record_access(logic cmd, logic [DATA_W-1:0] key,
                                    logic signed [DATA_W-1:0] val);
            int              eff;
            int              slot;
            bit              found;
            access_outcome_t outcome;
            outcome = '0;
            slot    = 0;
            found   = 1'b0;
            eff     = (capacity > TABLE_SLOTS) ? TABLE_SLOTS : int'(capacity);
            if (cmd == CMD_GET) gets++;
            else puts++;
            if (eff != 0) begin
                for (int i = 0; i < TABLE_SLOTS && !found; i++) begin
                    if (slot_valid[i] && slot_key[i] == key) begin
                        slot  = i;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    outcome.hit = 1'b1;
                    if (cmd == CMD_GET) outcome.read_value = slot_value[slot];
                    else slot_value[slot] = val;
                    if (slot_uses[slot] != '1) slot_uses[slot]++;
                    foreach (slot_valid[i]) begin
                        if (slot_valid[i] && i != slot && slot_rank[i] < slot_rank[slot])
                            slot_rank[i]++;
                    end
                    slot_rank[slot] = '0;
                end else if (cmd == CMD_PUT) begin
                    if (fill < eff) begin
                        for (int i = 0; i < TABLE_SLOTS && !found; i++) begin
                            if (!slot_valid[i]) begin
                                slot  = i;
                                found = 1'b1;
                            end
                        end
                    end
                    if (!found) begin
                        // victim: fewest uses, least recently touched on a tie
                        for (int i = 0; i < TABLE_SLOTS; i++) begin
                            if (slot_valid[i] && (!found || slot_uses[i] < slot_uses[slot] ||
                                (slot_uses[i] == slot_uses[slot] &&
                                 slot_rank[i] > slot_rank[slot]))) begin
                                slot  = i;
                                found = 1'b1;
                            end
                        end
                        if (found) begin
                            foreach (slot_valid[i]) begin
                                if (slot_valid[i] && i != slot && slot_rank[i] > slot_rank[slot])
                                    slot_rank[i]--;
                            end
                            slot_valid[slot] = 1'b0;
                            if (fill > 0) fill--;
                            outcome.evicted = 1'b1;
                        end
                    end
                    if (found) begin
                        foreach (slot_valid[i]) begin
                            if (slot_valid[i]) slot_rank[i]++;
                        end
                        slot_valid[slot] = 1'b1;
                        slot_key[slot]   = key;
                        slot_value[slot] = val;
                        slot_uses[slot]  = 32'd1;
                        slot_rank[slot]  = '0;
                        fill++;
                    end
                end
            end
            hits      += outcome.hit;
            evictions += outcome.evicted;
            pending_outcomes.push_back(outcome);
        endfunction

        function void compare_outcome(logic hit, logic signed [DATA_W-1:0] read_value,
                                      logic evicted);
            access_outcome_t want;
            results_seen++;
            if (pending_outcomes.size() == 0) begin
                note_mismatch($sformatf("result %0d hit=%0b read_value=%0d evicted=%0b, none expected",
                                        results_seen, hit, read_value, evicted));
                return;
            end
            want = pending_outcomes.pop_front();
            if (hit !== want.hit || read_value !== want.read_value || evicted !== want.evicted) begin
                note_mismatch($sformatf({"result %0d: expected hit=%0b read_value=%0d evicted=%0b,",
                                         " got hit=%0b read_value=%0d evicted=%0b"},
                                        results_seen, want.hit, want.read_value, want.evicted,
                                        hit, read_value, evicted));
            end
        endfunction
    endclass

endpackage

FILE: verif/lfu_cache_table_core_test.sv
`timescale 1ns / 100ps
// testbench top: random and directed get/put traffic against the lfu cache table core
module lfu_cache_table_core_test;
    import lfuc_pkg::*;
    import lfu_cache_mirror_pkg::*;

    localparam int GAP_MAX        = 13;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int STALL_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 2 * TABLE_SLOTS + 10;
    localparam int POOL_SIZE      = 24;
    localparam int PHASE_ITEMS    = 85;
    localparam int PHASE_COUNT    = 11;
    localparam logic [APB_AW-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic                     s_command     = CMD_GET;
    logic [31:0]              s_lookup_key  = '0;
    logic signed [31:0]       s_write_value = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic                     m_hit;
    logic signed [31:0]       m_read_value;
    logic                     m_evicted;
    logic                     psel          = 1'b0;
    logic                     penable       = 1'b0;
    logic                     pwrite        = 1'b0;
    logic [APB_AW-1:0]        paddr         = '0;
    logic [APB_DW-1:0]        pwdata        = '0;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;

    bit                       idle_on       = 1'b1;
    bit                       hold_request  = 1'b0;
    int                       quiet_cycles  = 0;
    int                       settings_used = 0;
    logic [31:0]              key_pool [POOL_SIZE];
    lfu_cache_mirror          cache_mirror  = new();

    always #1 aclk = ~aclk;

    lfu_cache_table_core #(.MAX_ENTRIES(TABLE_SLOTS)) i_dut (.*);

    function automatic int draw_gap();
        return idle_on ? int'($urandom_range(0, GAP_MAX)) : 0;
    endfunction

    task automatic send_access(logic cmd, logic [31:0] key, logic signed [31:0] val);
        int gap;
        gap = draw_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_lookup_key  <= key;
        s_write_value <= val;
        do @(posedge aclk); while (!s_ready);
        cache_mirror.record_access(cmd, key, val);
    endtask

    task automatic end_burst();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_quiet();
        while (cache_mirror.pending_outcomes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apb_access(logic write, logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_capacity(int cap);
        logic [APB_DW-1:0] readback;
        wait_quiet();
        apb_access(1'b1, APB_DW'(cap), readback);
        cache_mirror.capacity = CAP_W'(cap);
        apb_access(1'b0, '0, readback);
        if (readback[CAP_W-1:0] !== CAP_W'(cap)) begin
            cache_mirror.note_mismatch($sformatf("capacity readback: expected %0d, got %0d",
                                                 cap, readback[CAP_W-1:0]));
        end
        settings_used++;
    endtask

    task automatic run_phase(int cap, bit idle, bit squeeze);
        int                 eff;
        int                 window;
        int                 pick;
        logic               cmd;
        logic [31:0]        key;
        logic signed [31:0] val;
        set_capacity(cap);
        idle_on = idle;
        eff = (cap > TABLE_SLOTS) ? TABLE_SLOTS : cap;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            window = (eff == 0) ? 6 : eff + int'($urandom_range(1, 4));
            if (window > POOL_SIZE) window = POOL_SIZE;
            pick = $urandom_range(0, 99);
            // hot keys build up use counts, the rest compete for the cold slots
            if (pick < 45) key = key_pool[$urandom_range(0, (window + 3) / 4 - 1)];
            else if (pick < 88) key = key_pool[$urandom_range(0, window - 1)];
            else if (pick < 94) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else key = $urandom;
            cmd  = ($urandom_range(0, 99) < 45) ? CMD_PUT : CMD_GET;
            pick = $urandom_range(0, 99);
            if (pick < 5) val = 32'sh80000000;
            else if (pick < 10) val = 32'sh7fffffff;
            else val = $urandom;
            if (squeeze && n == 20) hold_request = 1'b1;
            send_access(cmd, key, val);
        end
        end_burst();
    endtask

    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall = SQUEEZE_CYCLES;
            end else begin
                stall = draw_gap();
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            cache_mirror.compare_outcome(m_hit, m_read_value, m_evicted);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        int phase_caps [PHASE_COUNT];
        phase_caps = '{16, 3, 1, 31, 0, 5, 16, 2, 17, 8, 16};
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // two-entry table: empty miss, fills, hits, tie and count based victims
        set_capacity(2);
        send_access(CMD_GET, 32'h0, 32'sh1234);
        send_access(CMD_PUT, 32'h0, 32'sh7fffffff);
        send_access(CMD_PUT, 32'hffffffff, 32'sh80000000);
        send_access(CMD_GET, 32'h0, '0);
        send_access(CMD_GET, 32'hffffffff, 32'shffffffff);
        send_access(CMD_PUT, 32'h5, 32'shffffffff);
        send_access(CMD_PUT, 32'hffffffff, 32'sh1);
        send_access(CMD_GET, 32'h0, '0);
        send_access(CMD_GET, 32'h5, '0);
        send_access(CMD_PUT, 32'h7, 32'sh55aa55aa);
        end_burst();

        // disabled table leaves stored entries alone
        set_capacity(0);
        send_access(CMD_PUT, 32'h9, 32'sh0badcafe);
        send_access(CMD_GET, 32'hffffffff, '0);
        end_burst();

        // capacity above the table size saturates
        set_capacity(31);
        send_access(CMD_GET, 32'hffffffff, '0);
        send_access(CMD_PUT, 32'h5, 32'sh12345678);
        send_access(CMD_GET, 32'h7, '0);
        end_burst();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            run_phase(phase_caps[p], (p % 3) != 2, p == 2 || p == 6);
        end

        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("covered %0d transactions (%0d gets, %0d puts) with %0d hits and %0d evictions",
                 cache_mirror.gets + cache_mirror.puts, cache_mirror.gets, cache_mirror.puts,
                 cache_mirror.hits, cache_mirror.evictions);
        $display("%0d capacity settings from 0 to 31, random idling and long result back-pressure",
                 settings_used);
        if (cache_mirror.mismatches == 0 && cache_mirror.pending_outcomes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
